// ----- hw/rtl/pctg_pkg.sv -----
// Shared constants, types and sine table builder for the pulsed complex tone generator.
package pctg_pkg;

  localparam int unsigned PHASE_BITS      = 32;
  localparam int unsigned TABLE_ADDR_BITS = 10;
  localparam int unsigned COUNT_BITS      = 24;
  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned MAG_BITS        = SAMPLE_BITS - 1;
  localparam int unsigned TABLE_LEN       = 1 << TABLE_ADDR_BITS;
  localparam int unsigned CFG_IDX_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS   = 32;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_PHASE_OFFSET  = 2'd1,
    REG_PULSE_LENGTH  = 2'd2,
    REG_PERIOD_LENGTH = 2'd3
  } reg_idx_e;

  // Live configuration, with the last index of the effective period precomputed
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_step;
    logic [PHASE_BITS-1:0] phase_offset;
    logic [COUNT_BITS-1:0] pulse_length;
    logic [COUNT_BITS-1:0] last_index;
  } cfg_t;

  // Table addresses for one sample
  typedef struct packed {
    logic [TABLE_ADDR_BITS-1:0] addr_sin;
    logic [TABLE_ADDR_BITS-1:0] addr_cos;
  } lookup_addr_t;

  // Flags that travel alongside the table read
  typedef struct packed {
    logic in_pulse;
    logic last;
    logic neg_sin;
    logic neg_cos;
  } lookup_tag_t;

  typedef logic [MAG_BITS-1:0] mag_t;
  typedef mag_t table_t [TABLE_LEN];

  localparam logic [63:0] Q62_ONE   = 64'd1 << 62;
  localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C234;
  localparam logic [63:0] AMPLITUDE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // Taylor series divisors (2n)(2n+1) for n = 1 .. 12
  localparam logic [63:0] HORNER_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Full 128-bit product shifted right, low 64 bits kept
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  // One quarter-wave entry, sine at the centre of bin k in Q62 scaled to the amplitude, rounded half up
  function automatic mag_t table_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] r;
    x  = mul_shr(PI_Q62, 64'(2 * k + 1), TABLE_ADDR_BITS + 2);
    x2 = mul_shr(x, x, 62);
    t  = Q62_ONE;
    for (int n = 12; n >= 1; n--) begin
      t = Q62_ONE - (mul_shr(x2, t, 62) / HORNER_DIV[n-1]);
    end
    t = mul_shr(x, t, 62);
    r = (mul_shr(t, AMPLITUDE, 61) + 64'd1) >> 1;
    return r[MAG_BITS-1:0];
  endfunction

  function automatic table_t build_table();
    table_t tbl;
    for (int k = 0; k < TABLE_LEN; k++) begin
      tbl[k] = table_entry(k);
    end
    return tbl;
  endfunction

  localparam table_t SINE_TABLE = build_table();

  // Last sample index of the effective period: max(period, pulse, 1) - 1
  function automatic logic [COUNT_BITS-1:0] eff_last(logic [COUNT_BITS-1:0] pulse,
                                                     logic [COUNT_BITS-1:0] period);
    logic [COUNT_BITS-1:0] m;
    m = (period < pulse) ? pulse : period;
    return (m == '0) ? '0 : m - COUNT_BITS'(1);
  endfunction

endpackage

// ----- hw/rtl/pctg_if.sv -----
// Handshake channel interfaces: request word, sample word and register write.
interface pctg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface pctg_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pctg_pkg::SAMPLE_BITS-1:0]  sample_i;
  logic signed [pctg_pkg::SAMPLE_BITS-1:0]  sample_q;
  logic                                     in_pulse;
  logic                                     period_last;
  modport source (output valid, output sample_i, output sample_q, output in_pulse,
                  output period_last, input ready);
  modport sink   (input valid, input sample_i, input sample_q, input in_pulse,
                  input period_last, output ready);
endinterface

interface pctg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pctg_pkg::CFG_IDX_BITS-1:0]  index;
  logic [pctg_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/pctg_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module pctg_ram #(
  parameter int unsigned  WIDTH     = 16,
  parameter int unsigned  DEPTH     = 1024,
  localparam int unsigned ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_a_i,
  input  logic [ADDR_BITS-1:0] raddr_b_i,
  output logic [WIDTH-1:0]     rdata_a_o,
  output logic [WIDTH-1:0]     rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ----- hw/rtl/pctg_cfg.sv -----
// Configuration registers and the precomputed period end.
module pctg_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  pctg_cfg_if.sink         cfg_i,
  output pctg_pkg::cfg_t   cfg_o
);
  import pctg_pkg::*;

  logic [PHASE_BITS-1:0] step_q, offset_q;
  logic [COUNT_BITS-1:0] pulse_q, period_q, last_q;
  logic [COUNT_BITS-1:0] wlen;
  logic                  wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid && cfg_i.ready;
  assign wlen        = cfg_i.data[COUNT_BITS-1:0];

  // Take a register word, refresh the period end on length writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      offset_q <= '0;
      pulse_q  <= COUNT_BITS'(1);
      period_q <= '0;
      last_q   <= '0;
    end else if (wr) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_PHASE_STEP:    step_q   <= cfg_i.data[PHASE_BITS-1:0];
        REG_PHASE_OFFSET:  offset_q <= cfg_i.data[PHASE_BITS-1:0];
        REG_PULSE_LENGTH: begin
          pulse_q <= wlen;
          last_q  <= eff_last(wlen, period_q);
        end
        REG_PERIOD_LENGTH: begin
          period_q <= wlen;
          last_q   <= eff_last(pulse_q, wlen);
        end
        default: ;
      endcase
    end
  end

  assign cfg_o.phase_step   = step_q;
  assign cfg_o.phase_offset = offset_q;
  assign cfg_o.pulse_length = pulse_q;
  assign cfg_o.last_index   = last_q;

endmodule

// ----- hw/rtl/pctg_phase.sv -----
// Sample index and phase accumulator; forms table addresses for each request.
module pctg_phase (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        restart_i,
  input  pctg_pkg::cfg_t              cfg_i,
  output pctg_pkg::lookup_addr_t      addr_o,
  output pctg_pkg::lookup_tag_t       tag_o
);
  import pctg_pkg::*;

  logic [COUNT_BITS-1:0]      idx_q, idx_d, n;
  logic [PHASE_BITS-1:0]      acc_q, acc_d, p;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] k;
  lookup_tag_t                tag_d, tag_q;

  // Position and phase of this sample
  always_comb begin
    n              = restart_i ? '0 : idx_q;
    p              = (n == '0) ? cfg_i.phase_offset : acc_q;
    tag_d.in_pulse = n < cfg_i.pulse_length;
    tag_d.last     = n >= cfg_i.last_index;
    acc_d          = tag_d.in_pulse ? p + cfg_i.phase_step : p;
    idx_d          = tag_d.last ? '0 : n + COUNT_BITS'(1);
    quad           = p[PHASE_BITS-1 -: 2];
    k              = p[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    // Odd quadrants mirror the index; cosine is a quarter turn ahead
    addr_o.addr_sin = quad[0] ? ~k : k;
    addr_o.addr_cos = quad[0] ? k : ~k;
    tag_d.neg_sin   = quad[1];
    tag_d.neg_cos   = quad[1] ^ quad[0];
  end

  // Advance state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      acc_q <= '0;
    end else if (accept_i) begin
      idx_q <= idx_d;
      acc_q <= acc_d;
    end
  end

  // Flags alongside the table read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      tag_q <= tag_d;
    end
  end

  assign tag_o = tag_q;

endmodule

// ----- hw/rtl/pctg_lut.sv -----
// Quarter-wave sine memory with its load sweep after reset.
module pctg_lut (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  pctg_pkg::lookup_addr_t addr_i,
  output pctg_pkg::mag_t         mag_sin_o,
  output pctg_pkg::mag_t         mag_cos_o,
  output logic                   loaded_o
);
  import pctg_pkg::*;

  logic [TABLE_ADDR_BITS:0] fill_q, fill_d;

  assign loaded_o = fill_q[TABLE_ADDR_BITS];
  assign fill_d   = fill_q + (TABLE_ADDR_BITS+1)'(1);

  // Sweep the table in, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (!loaded_o) begin
      fill_q <= fill_d;
    end
  end

  pctg_ram #(
    .WIDTH (MAG_BITS),
    .DEPTH (TABLE_LEN)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (!loaded_o),
    .waddr_i   (fill_q[TABLE_ADDR_BITS-1:0]),
    .wdata_i   (SINE_TABLE[fill_q[TABLE_ADDR_BITS-1:0]]),
    .re_i      (rd_en_i),
    .raddr_a_i (addr_i.addr_sin),
    .raddr_b_i (addr_i.addr_cos),
    .rdata_a_o (mag_sin_o),
    .rdata_b_o (mag_cos_o)
  );

endmodule

// ----- hw/rtl/pctg_out.sv -----
// Sign and padding of the looked-up magnitudes, and the result register.
module pctg_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s1_valid_i,
  input  pctg_pkg::lookup_tag_t tag_i,
  input  pctg_pkg::mag_t        mag_sin_i,
  input  pctg_pkg::mag_t        mag_cos_i,
  output logic                  s1_take_o,
  pctg_out_if.source            out_o
);
  import pctg_pkg::*;

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] si_d, sq_d, si_q, sq_q;
  logic                          pulse_q, last_q;
  logic signed [SAMPLE_BITS-1:0] sin_ext, cos_ext;

  assign s1_take_o = s1_valid_i && (!valid_q || out_o.ready);

  // Apply quadrant sign, zero in padding
  always_comb begin
    sin_ext = $signed({1'b0, mag_sin_i});
    cos_ext = $signed({1'b0, mag_cos_i});
    sq_d    = tag_i.neg_sin ? -sin_ext : sin_ext;
    si_d    = tag_i.neg_cos ? -cos_ext : cos_ext;
    if (!tag_i.in_pulse) begin
      sq_d = '0;
      si_d = '0;
    end
  end

  // Hold the word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s1_take_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take_o) begin
      si_q    <= si_d;
      sq_q    <= sq_d;
      pulse_q <= tag_i.in_pulse;
      last_q  <= tag_i.last;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.sample_i    = si_q;
  assign out_o.sample_q    = sq_q;
  assign out_o.in_pulse    = pulse_q;
  assign out_o.period_last = last_q;

endmodule

// ----- hw/rtl/pulsed_complex_tone_generator.sv -----
// Top level of the pulsed complex tone generator.
// Each request word yields one I/Q sample word; one word can be taken every clock when the
// sample channel does not stall; a sample passes the table read, then the result register.
// Request ready follows the sample channel's ready combinationally through the two stages.
// While the quarter-wave sine memory is loaded after reset no request is taken; register
// writes are taken at any time and apply from the next request.
module pulsed_complex_tone_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  pctg_in_if.sink     in_i,
  pctg_out_if.source  out_o,
  pctg_cfg_if.sink    cfg_i
);
  import pctg_pkg::*;

  cfg_t         cfg;
  lookup_addr_t addr;
  lookup_tag_t  tag;
  mag_t         mag_sin, mag_cos;
  logic         loaded, accept, s1_valid_q, s1_take;

  assign in_i.ready = loaded && (!s1_valid_q || s1_take);
  assign accept     = in_i.valid && in_i.ready;

  // Track the word between table read and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  pctg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pctg_phase u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (in_i.restart),
    .cfg_i     (cfg),
    .addr_o    (addr),
    .tag_o     (tag)
  );

  pctg_lut u_lut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .addr_i    (addr),
    .mag_sin_o (mag_sin),
    .mag_cos_o (mag_cos),
    .loaded_o  (loaded)
  );

  pctg_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .tag_i      (tag),
    .mag_sin_i  (mag_sin),
    .mag_cos_i  (mag_cos),
    .s1_take_o  (s1_take),
    .out_o      (out_o)
  );

endmodule

// ----- hw/rtl/pctg_checker.sv -----
// Port-level checks for the pulsed complex tone generator, bound to the top level.
module pctg_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_ready_i,
  input logic                                    out_valid_i,
  input logic                                    out_ready_i,
  input logic signed [pctg_pkg::SAMPLE_BITS-1:0] sample_i_i,
  input logic signed [pctg_pkg::SAMPLE_BITS-1:0] sample_q_i,
  input logic                                    in_pulse_i
);
  import pctg_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] MostNeg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // A stalled sample word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("sample word dropped while stalled");

  // No request ready as reset is released, when the table load begins
  a_load_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("request ready during table load");

  // Padding words carry zeros
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !in_pulse_i |-> sample_i_i == '0 && sample_q_i == '0)
    else $error("non-zero sample in padding");

  // Symmetric amplitude: the most negative code never appears
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sample_i_i != MostNeg && sample_q_i != MostNeg)
    else $error("sample outside symmetric range");

endmodule

bind pulsed_complex_tone_generator pctg_checker u_pctg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sample_i_i  (out_o.sample_i),
  .sample_q_i  (out_o.sample_q),
  .in_pulse_i  (out_o.in_pulse)
);

// ----- verif/pulsed_complex_tone_generator_tb.sv -----
// Self-checking testbench for the pulsed complex tone generator: sample words against a tone model.
module pulsed_complex_tone_generator_tb;
  import pctg_pkg::*;

  // One expected sample word
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] cos_val;
    logic signed [SAMPLE_BITS-1:0] sin_val;
    logic                          in_pulse;
    logic                          period_last;
  } tone_word_t;

  localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1) << (PHASE_BITS - 2);
  localparam logic [63:0]           FX_ONE       = 64'd1 << 62;
  localparam logic [63:0]           FX_PI        = 64'hC90FDAA22168C234;

  logic clk_i;
  logic rst_ni;

  pctg_in_if  req_if ();
  pctg_out_if tone_if ();
  pctg_cfg_if cfg_if ();

  pulsed_complex_tone_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (tone_if),
    .cfg_i  (cfg_if)
  );

  // Tone model state and register copies
  logic [PHASE_BITS-1:0] set_step;
  logic [PHASE_BITS-1:0] set_offset;
  logic [COUNT_BITS-1:0] set_pulse;
  logic [COUNT_BITS-1:0] set_period;
  logic [PHASE_BITS-1:0] tone_phase;
  logic [COUNT_BITS-1:0] tone_index;
  logic [MAG_BITS-1:0]   quarter_sine [TABLE_LEN];

  bit         queued_restarts [$];
  tone_word_t awaited_words [$];

  int send_gap_pct   = 0;
  int sink_stall_pct = 0;
  int hold_asked     = 0;
  int hold_granted   = 0;
  int hold_left      = 0;
  int error_count    = 0;
  int words_sent     = 0;
  int words_checked  = 0;
  int pulse_words    = 0;
  int period_ends    = 0;
  int settings_count = 0;

  // Clock: period of 20
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Fixed point product, shifted right and cut to 64 bits
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    wide = wide >> sh;
    return wide[63:0];
  endfunction

  // Sine at the centre of quarter-wave bin k, Horner-evaluated Taylor series in Q62
  function automatic logic [MAG_BITS-1:0] quarter_wave_mag(int k);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] acc;
    logic [63:0] scaled;
    ang    = fx_mul(FX_PI, 64'(2 * k + 1), TABLE_ADDR_BITS + 2);
    ang_sq = fx_mul(ang, ang, 62);
    acc    = FX_ONE;
    for (int n = 12; n >= 1; n--) begin
      acc = FX_ONE - fx_mul(ang_sq, acc, 62) / 64'(2 * n * (2 * n + 1));
    end
    acc    = fx_mul(ang, acc, 62);
    scaled = (fx_mul(acc, (64'd1 << (SAMPLE_BITS - 1)) - 64'd1, 61) + 64'd1) >> 1;
    return scaled[MAG_BITS-1:0];
  endfunction

  // Signed sine of a phase from the quarter-wave table
  function automatic logic signed [SAMPLE_BITS-1:0] tone_sine(logic [PHASE_BITS-1:0] ph);
    logic [1:0]                    quad;
    logic [TABLE_ADDR_BITS-1:0]    k;
    logic signed [SAMPLE_BITS-1:0] mag;
    quad = ph[PHASE_BITS-1 -: 2];
    k    = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    if (quad[0]) k = ~k;
    mag = {1'b0, quarter_sine[k]};
    return quad[1] ? -mag : mag;
  endfunction

  // Work out the sample word for one request and advance the tone state
  function automatic tone_word_t generate_tone_word(bit restart);
    tone_word_t            w;
    logic [COUNT_BITS-1:0] span_last;
    span_last = (set_period < set_pulse) ? set_pulse : set_period;
    if (span_last != '0) span_last = span_last - COUNT_BITS'(1);
    if (restart) tone_index = '0;
    if (tone_index == '0) tone_phase = set_offset;
    w.in_pulse    = (tone_index < set_pulse);
    w.period_last = (tone_index >= span_last);
    if (w.in_pulse) begin
      w.sin_val  = tone_sine(tone_phase);
      w.cos_val  = tone_sine(tone_phase + QUARTER_TURN);
      tone_phase = tone_phase + set_step;
    end else begin
      w.sin_val = '0;
      w.cos_val = '0;
    end
    tone_index = w.period_last ? '0 : tone_index + COUNT_BITS'(1);
    return w;
  endfunction

  // Request driver: record accepted words, then offer the next or go idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.restart <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_words.push_back(generate_tone_word(req_if.restart));
        words_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (queued_restarts.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req_if.valid   <= 1'b1;
          req_if.restart <= queued_restarts.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the sample channel, counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_granted) begin
      hold_left    <= 400;
      hold_granted <= hold_granted + 1;
    end
  end

  // Sample monitor: check each accepted word against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    tone_word_t exp_word;
    if (!rst_ni) begin
      tone_if.ready <= 1'b0;
    end else begin
      if (tone_if.valid && tone_if.ready) begin
        if (awaited_words.size() == 0) begin
          $error("sample word with no request outstanding");
          error_count++;
        end else begin
          exp_word = awaited_words.pop_front();
          words_checked++;
          if (exp_word.in_pulse) pulse_words++;
          if (exp_word.period_last) period_ends++;
          if (tone_if.sample_i !== exp_word.cos_val) begin
            $error("sample_i: expected %0d, got %0d", exp_word.cos_val, tone_if.sample_i);
            error_count++;
          end
          if (tone_if.sample_q !== exp_word.sin_val) begin
            $error("sample_q: expected %0d, got %0d", exp_word.sin_val, tone_if.sample_q);
            error_count++;
          end
          if (tone_if.in_pulse !== exp_word.in_pulse) begin
            $error("in_pulse: expected %0b, got %0b", exp_word.in_pulse, tone_if.in_pulse);
            error_count++;
          end
          if (tone_if.period_last !== exp_word.period_last) begin
            $error("period_last: expected %0b, got %0b", exp_word.period_last,
                   tone_if.period_last);
            error_count++;
          end
        end
      end
      tone_if.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Write one register and mirror it in the model
  task automatic program_reg(reg_idx_e idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_PHASE_STEP:    set_step   = val[PHASE_BITS-1:0];
      REG_PHASE_OFFSET:  set_offset = val[PHASE_BITS-1:0];
      REG_PULSE_LENGTH:  set_pulse  = val[COUNT_BITS-1:0];
      REG_PERIOD_LENGTH: set_period = val[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_all(logic [31:0] step, logic [31:0] offset,
                             logic [31:0] pulse, logic [31:0] period);
    program_reg(REG_PHASE_STEP, step);
    program_reg(REG_PHASE_OFFSET, offset);
    program_reg(REG_PULSE_LENGTH, pulse);
    program_reg(REG_PERIOD_LENGTH, period);
    settings_count++;
  endtask

  // Hold until every queued request is taken and every sample word is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_restarts.size() != 0 || req_if.valid || awaited_words.size() != 0);
  endtask

  task automatic queue_requests(int count, int restart_pct);
    for (int n = 0; n < count; n++) begin
      queued_restarts.push_back($urandom_range(99) < restart_pct);
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
      1: begin send_gap_pct = 87; sink_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  sink_stall_pct = 87; end
      default: begin send_gap_pct = 11; sink_stall_pct = 11; end
    endcase
  endtask

  // Pick a random register set, mostly short pulses and periods, sometimes the extremes
  task automatic random_settings();
    logic [31:0] step;
    logic [31:0] offset;
    logic [31:0] pulse;
    logic [31:0] period;
    case ($urandom_range(7))
      0:       step = '0;
      1:       step = '1;
      2:       step = 32'h8000_0000;
      3:       step = $urandom_range(4095);
      default: step = $urandom();
    endcase
    case ($urandom_range(5))
      0:       offset = '0;
      1:       offset = '1;
      default: offset = $urandom();
    endcase
    pulse  = $urandom();
    period = $urandom();
    case ($urandom_range(9))
      0:       pulse[23:0] = '0;
      1:       pulse[23:0] = '1;
      2:       pulse[23:0] = 24'd1;
      default: pulse[23:0] = 24'($urandom_range(40, 2));
    endcase
    case ($urandom_range(9))
      0:       period[23:0] = '0;
      1:       period[23:0] = '1;
      2:       period[23:0] = 24'd1;
      default: period[23:0] = 24'($urandom_range(60));
    endcase
    program_all(step, offset, pulse, period);
  endtask

  // Stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_PHASE_STEP;
    cfg_if.data    = '0;
    set_step       = '0;
    set_offset     = '0;
    set_pulse      = COUNT_BITS'(1);
    set_period     = '0;
    tone_phase     = '0;
    tone_index     = '0;
    for (int k = 0; k < TABLE_LEN; k++) begin
      quarter_sine[k] = quarter_wave_mag(k);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one-sample pulse, no padding, restart both ways
    set_idling(0);
    queued_restarts.push_back(1'b0);
    queued_restarts.push_back(1'b1);
    queued_restarts.push_back(1'b0);
    wait_drained();

    // Quarter-turn steps through a padded period, restart in the middle
    program_all(32'h4000_0000, 32'h0000_0000, 32'd3, 32'd6);
    queued_restarts = '{0, 0, 0, 0, 1, 0, 0};
    wait_drained();

    // Zero pulse length: padding only
    program_all(32'h1234_5678, 32'h4000_0000, 32'hFF00_0000, 32'd3);
    queued_restarts = '{0, 0, 0};
    wait_drained();

    // Full-scale step and offset, then shrink the period below the current index
    program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4, 32'd30);
    queued_restarts = '{1, 0, 0, 0, 0, 0, 0, 0};
    wait_drained();
    program_reg(REG_PERIOD_LENGTH, 32'd5);
    queued_restarts = '{0, 0};
    wait_drained();

    // Sample channel held off while requests keep coming, so the block backs up
    random_settings();
    set_idling(0);
    hold_asked++;
    queue_requests(120, 3);
    wait_drained();

    // Random settings and idling, every mode in turn
    for (int ph = 0; ph < 22; ph++) begin
      random_settings();
      set_idling(ph % 4);
      queue_requests($urandom_range(100, 50), 5);
      // pause the sender until everything is back, then carry on without a write
      if (ph % 5 == 4) begin
        wait_drained();
        queue_requests(20, 5);
      end
      wait_drained();
    end

    // Last word back; allow the pipeline to show any stray word
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("%0d requests and %0d sample words checked over %0d register settings",
             words_sent, words_checked, settings_count);
    $display("%0d words inside a pulse, %0d period ends", pulse_words, period_ends);
    if (error_count == 0) begin
      $display("pulsed_complex_tone_generator_tb: clean");
    end else begin
      $display("pulsed_complex_tone_generator_tb: errors");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5_000_000;
    $display("pulsed_complex_tone_generator_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pctg_pkg.sv
hw/rtl/pctg_if.sv
hw/rtl/pctg_ram.sv
hw/rtl/pctg_cfg.sv
hw/rtl/pctg_phase.sv
hw/rtl/pctg_lut.sv
hw/rtl/pctg_out.sv
hw/rtl/pulsed_complex_tone_generator.sv
hw/rtl/pctg_checker.sv
verif/pulsed_complex_tone_generator_tb.sv
